>>> rtl/hks_pkg.sv
// Shared package for the hashed key set: request and result types, the
// controller/datapath command and status structs, opcodes and status codes.
// Depends on nothing; every other file imports it.
package hks_pkg;

  // Hash settings.
  localparam int          HASH_W     = 64;
  localparam logic [63:0] HASH_START = 64'd5381;

  // Default sizes handed to the top level.
  localparam int BUCKET_COUNT_DEF     = 64;
  localparam int SLOTS_PER_BUCKET_DEF = 1;
  localparam int MAX_KEY_BYTES_DEF    = 16;

  // Opcodes (any other code behaves as a find).
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_FIND   = 2'd2;

  // Status codes of a result.
  localparam logic [2:0] ST_ADDED       = 3'd0;
  localparam logic [2:0] ST_COLLISION   = 3'd1;
  localparam logic [2:0] ST_FOUND       = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_REMOVED     = 3'd4;
  localparam logic [2:0] ST_REMOVE_MISS = 3'd5;
  localparam logic [2:0] ST_TOO_LONG    = 3'd6;

  // One request: a key byte with its opcode and last-byte mark.
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] key_byte;
    logic       last;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic [2:0] status;
    logic [5:0] bucket;
    logic [2:0] slot;
  } out_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // take the request on the input ports
    logic clr_step;  // clear one bucket of lengths
    logic rd;        // read the bucket lengths and the first slot's key
    logic cmp;       // compare the current slot, finish when done
    logic fail;      // report a key that was too long
  } hks_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // clearing pass is at its last bucket
    logic too_long;  // the buffered key overflowed
    logic mod_done;  // bucket index is ready
    logic cmp_done;  // current slot matched or was the last one
  } hks_sts_t;

endpackage

>>> rtl/hks_mod.sv
// Bucket index unit: reduces the 64-bit key hash modulo the bucket count.
// Uses hks_pkg. A power-of-two count is a mask; otherwise a byte fold and a
// reciprocal multiplication, registered in val_r, sum_r, quo_r and rem_r.
module hks_mod
  import hks_pkg::*;
#(
  parameter int BUCKET_COUNT = BUCKET_COUNT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  logic [HASH_W-1:0]               value,
  output logic [$clog2(BUCKET_COUNT)-1:0] rem,
  output logic                            done
);

  localparam int BKT_W  = $clog2(BUCKET_COUNT);
  localparam int NBYTES = HASH_W / 8;

  // Weight of each hash byte modulo the bucket count, 256^i mod count.
  function automatic logic [NBYTES*BKT_W-1:0] byte_weights();
    logic [NBYTES*BKT_W-1:0] w;
    int                      p;
    w = '0;
    p = 1 % BUCKET_COUNT;
    for (int i = 0; i < NBYTES; i++) begin
      w[BKT_W*i +: BKT_W] = BKT_W'(p);
      p = (p * 256) % BUCKET_COUNT;
    end
    return w;
  endfunction

  generate
    if ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0) begin : g_mask
      logic [BKT_W-1:0] rem_r;

      // The low hash bits are the bucket directly.
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          rem_r <= '0;
        end else if (load) begin
          rem_r <= value[BKT_W-1:0];
        end
      end

      assign rem  = rem_r;
      assign done = 1'b1;
    end else begin : g_fold
      // Eight byte terms below 2^(8 + BKT_W) each.
      localparam int SUM_W  = BKT_W + 11;
      localparam int RS     = SUM_W + BKT_W;
      localparam int RCP_W  = SUM_W + 1;
      localparam int PROD_W = SUM_W + RCP_W;
      localparam int Q_W    = PROD_W - RS;
      localparam logic [NBYTES*BKT_W-1:0] WEIGHTS = byte_weights();
      localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << RS) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT));
      localparam logic [1:0] FOLD_CYCLES = 2'd3;

      logic [HASH_W-1:0] val_r;
      logic [SUM_W-1:0]  fold;
      logic [SUM_W-1:0]  sum_r;
      logic [PROD_W-1:0] prod;
      logic [Q_W-1:0]    quo_r;
      logic [SUM_W-1:0]  back;
      logic [SUM_W-1:0]  diff;
      logic [BKT_W-1:0]  rem_r;
      logic [1:0]        cnt_r;
      logic [1:0]        cnt_nxt;

      // Fold the bytes into a small value with the same remainder.
      always_comb begin
        fold = '0;
        for (int i = 0; i < NBYTES; i++) begin
          fold = fold + SUM_W'(val_r[8*i +: 8]) * SUM_W'(WEIGHTS[BKT_W*i +: BKT_W]);
        end
      end

      // Quotient by reciprocal multiplication, exact for every folded value.
      assign prod = PROD_W'(sum_r) * PROD_W'(RECIP);
      assign back = SUM_W'(SUM_W'(quo_r) * SUM_W'(BUCKET_COUNT));
      assign diff = sum_r - back;

      // Pipeline stages hold steady while the hash input is unchanged.
      always_ff @(posedge clk) begin
        if (load) begin
          val_r <= value;
        end
        sum_r <= fold;
        quo_r <= prod[PROD_W-1:RS];
        rem_r <= diff[BKT_W-1:0];
      end

      // Cycles left until the remainder is valid.
      always_comb begin
        cnt_nxt = cnt_r;
        if (load) begin
          cnt_nxt = FOLD_CYCLES;
        end else if (cnt_r != 2'd0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          cnt_r <= 2'd0;
        end else begin
          cnt_r <= cnt_nxt;
        end
      end

      assign rem  = rem_r;
      assign done = (cnt_r == 2'd0);
    end
  endgenerate

endmodule

>>> rtl/hks_ctrl.sv
// Controller of the hashed key set: sequences the clearing pass, byte intake,
// bucket lookup and slot compares. Uses hks_pkg; drives the datapath by hks_cmd_t.
module hks_ctrl
  import hks_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     in_last,
  input  hks_sts_t sts,
  output hks_cmd_t cmd,
  output logic     busy
);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_CMP   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (in_last) begin
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (sts.too_long) begin
          cmd.fail  = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.mod_done) begin
          cmd.rd    = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.cmp_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> rtl/hks_dp.sv
// Datapath of the hashed key set: key buffer, running hash, bucket memories,
// slot compare and the result register. Uses hks_pkg and hks_mod.
module hks_dp
  import hks_pkg::*;
#(
  parameter int BUCKET_COUNT     = BUCKET_COUNT_DEF,
  parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF,
  parameter int MAX_KEY_BYTES    = MAX_KEY_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_req_t  in_req,
  input  hks_cmd_t cmd,
  output hks_sts_t sts,
  output logic     out_strobe,
  output out_rsp_t out_rsp
);

  localparam int BKT_W   = $clog2(BUCKET_COUNT);
  localparam int SLOT_W  = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int ENTRIES = BUCKET_COUNT * SLOTS_PER_BUCKET;
  localparam int ENT_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(MAX_KEY_BYTES + 1);
  localparam int IDX_W   = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  typedef logic [SLOTS_PER_BUCKET-1:0][CNT_W-1:0] len_row_t;
  typedef logic [MAX_KEY_BYTES-1:0][7:0]          key_row_t;

  // Key intake state.
  logic [HASH_W-1:0] hash_r;
  logic [HASH_W-1:0] hash_nxt;
  logic [HASH_W-1:0] hash_calc;
  key_row_t          key_buf_r;
  key_row_t          key_buf_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              too_long_r;
  logic              too_long_nxt;
  logic [1:0]        op_r;

  // Lookup state.
  logic [BKT_W-1:0]  clr_idx_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] slot_nxt;
  logic [BKT_W-1:0]  bucket;
  logic              mod_done;
  logic [ENT_W-1:0]  base;

  // Memories and their registered read data.
  len_row_t len_mem [BUCKET_COUNT];
  key_row_t key_mem [ENTRIES];
  len_row_t len_q_r;
  key_row_t key_q_r;

  // Memory ports.
  logic             len_we;
  logic [BKT_W-1:0] len_waddr;
  len_row_t         len_wdata;
  logic             key_we;
  logic [ENT_W-1:0] key_waddr;
  logic             key_re;
  logic [ENT_W-1:0] key_raddr;

  // Compare results.
  logic [CNT_W-1:0]  len_s;
  logic              bytes_eq;
  logic              hit;
  logic              slot_last;
  logic              cmp_done;
  logic              have_empty;
  logic [SLOT_W-1:0] empty_slot;
  logic              finish;

  // Result register.
  logic     out_strobe_r;
  out_rsp_t out_rsp_r;
  out_rsp_t out_rsp_nxt;

  // djb33x step: times 33 as shift and add, then XOR the byte.
  assign hash_calc = ((hash_r << 5) + hash_r) ^ {{(HASH_W - 8){1'b0}}, in_req.key_byte};

  assign finish = cmd.fail || (cmd.cmp && cmp_done);

  // Key intake: buffer bytes up to the limit, flag any overflow.
  always_comb begin
    hash_nxt     = hash_r;
    key_buf_nxt  = key_buf_r;
    count_nxt    = count_r;
    too_long_nxt = too_long_r;
    if (cmd.accept) begin
      hash_nxt = hash_calc;
      if (count_r < CNT_W'(MAX_KEY_BYTES)) begin
        key_buf_nxt[count_r[IDX_W-1:0]] = in_req.key_byte;
        count_nxt = count_r + 1'b1;
      end else begin
        too_long_nxt = 1'b1;
      end
    end else if (finish) begin
      hash_nxt     = HASH_START;
      count_nxt    = '0;
      too_long_nxt = 1'b0;
    end
  end

  // Bucket index from the final hash.
  hks_mod #(
    .BUCKET_COUNT(BUCKET_COUNT)
  ) u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .load (cmd.accept && in_req.last),
    .value(hash_calc),
    .rem  (bucket),
    .done (mod_done)
  );

  assign base = ENT_W'(ENT_W'(bucket) * ENT_W'(SLOTS_PER_BUCKET));

  // Compare the current slot against the buffered key.
  always_comb begin
    bytes_eq = 1'b1;
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      if (CNT_W'(i) < count_r && key_q_r[i] != key_buf_r[i]) begin
        bytes_eq = 1'b0;
      end
    end
  end

  assign len_s     = len_q_r[slot_r];
  assign hit       = (len_s != '0) && (len_s == count_r) && bytes_eq;
  assign slot_last = (slot_r == SLOT_W'(SLOTS_PER_BUCKET - 1));
  assign cmp_done  = hit || slot_last;

  // First empty slot of the bucket.
  always_comb begin
    have_empty = 1'b0;
    empty_slot = '0;
    for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
      if (len_q_r[i] == '0) begin
        have_empty = 1'b1;
        empty_slot = SLOT_W'(i);
      end
    end
  end

  // Slot walk and key row reads.
  always_comb begin
    slot_nxt  = slot_r;
    key_re    = 1'b0;
    key_raddr = base;
    if (cmd.rd) begin
      slot_nxt = '0;
      key_re   = 1'b1;
    end else if (cmd.cmp && !cmp_done) begin
      slot_nxt  = slot_r + 1'b1;
      key_re    = 1'b1;
      key_raddr = base + ENT_W'(slot_r) + 1'b1;
    end
  end

  // Operation outcome, store updates and the result.
  always_comb begin
    out_rsp_nxt = out_rsp_r;
    len_we      = 1'b0;
    len_waddr   = bucket;
    len_wdata   = len_q_r;
    key_we      = 1'b0;
    key_waddr   = base + ENT_W'(empty_slot);
    if (cmd.clr_step) begin
      len_we    = 1'b1;
      len_waddr = clr_idx_r;
      len_wdata = '0;
    end
    if (cmd.fail) begin
      out_rsp_nxt.status = ST_TOO_LONG;
      out_rsp_nxt.bucket = '0;
      out_rsp_nxt.slot   = '0;
    end else if (cmd.cmp && cmp_done) begin
      out_rsp_nxt.bucket = 6'(bucket);
      out_rsp_nxt.slot   = '0;
      if (op_r == OP_INSERT) begin
        if (hit) begin
          out_rsp_nxt.status = ST_COLLISION;
          out_rsp_nxt.slot   = 3'(slot_r);
        end else if (have_empty) begin
          out_rsp_nxt.status    = ST_ADDED;
          out_rsp_nxt.slot      = 3'(empty_slot);
          len_we                = 1'b1;
          len_wdata[empty_slot] = count_r;
          key_we                = 1'b1;
        end else begin
          out_rsp_nxt.status = ST_COLLISION;
        end
      end else if (op_r == OP_REMOVE) begin
        if (hit) begin
          out_rsp_nxt.status = ST_REMOVED;
          out_rsp_nxt.slot   = 3'(slot_r);
          len_we             = 1'b1;
          len_wdata[slot_r]  = '0;
        end else begin
          out_rsp_nxt.status = ST_REMOVE_MISS;
        end
      end else begin
        // Find, and the unused opcode that behaves as find.
        if (hit) begin
          out_rsp_nxt.status = ST_FOUND;
          out_rsp_nxt.slot   = 3'(slot_r);
        end else begin
          out_rsp_nxt.status = ST_NOT_FOUND;
        end
      end
    end
  end

  // Length memory: one row of slot lengths per bucket.
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    if (cmd.rd) begin
      len_q_r <= len_mem[bucket];
    end
  end

  // Key memory: one row of key bytes per slot.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_buf_r;
    end
    if (key_re) begin
      key_q_r <= key_mem[key_raddr];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_buf_r <= key_buf_nxt;
    slot_r    <= slot_nxt;
    out_rsp_r <= out_rsp_nxt;
    if (cmd.accept) begin
      op_r <= in_req.opcode;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r       <= HASH_START;
      count_r      <= '0;
      too_long_r   <= 1'b0;
      clr_idx_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      hash_r       <= hash_nxt;
      count_r      <= count_nxt;
      too_long_r   <= too_long_nxt;
      out_strobe_r <= finish;
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
    end
  end

  assign sts.clr_last = (clr_idx_r == BKT_W'(BUCKET_COUNT - 1));
  assign sts.too_long = too_long_r;
  assign sts.mod_done = mod_done;
  assign sts.cmp_done = cmp_done;

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

endmodule

>>> rtl/hashed_key_set.sv
// Hashed key set, bucketed by the djb33x hash; top level joining the
// controller and the datapath. Uses hks_pkg, hks_ctrl and hks_dp.
//
// Keys arrive one byte per request, first byte first, with the last byte
// marked; a request is taken when start is high and busy is low. Bytes before
// the last are taken one per cycle. After the last byte busy stays high
// through bucket selection (S_DIV) and then the slot compares (S_CMP), one
// slot examined at a time, set by the registered reads of the bucket's
// length row and of one slot's key row. A bucket count that is not a power
// of two adds the wait on the remainder pipeline (val_r, sum_r, quo_r, rem_r).
// A too-long key finishes in bucket selection, with no compare. The result
// shows on out_rsp with out_strobe high for exactly one cycle; the receiver
// cannot stall it, and a new byte may be taken in that same cycle. After
// reset the block is busy while it clears the slot lengths, one bucket per
// cycle.
module hashed_key_set
  import hks_pkg::*;
#(
  parameter int BUCKET_COUNT     = BUCKET_COUNT_DEF,
  parameter int SLOTS_PER_BUCKET = SLOTS_PER_BUCKET_DEF,
  parameter int MAX_KEY_BYTES    = MAX_KEY_BYTES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_strobe,
  output out_rsp_t out_rsp
);

  hks_cmd_t cmd;
  hks_sts_t sts;

  // Sequencing.
  hks_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_last(in_req.last),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Storage, hashing and compare.
  hks_dp #(
    .BUCKET_COUNT    (BUCKET_COUNT),
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET),
    .MAX_KEY_BYTES   (MAX_KEY_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_strobe(out_strobe),
    .out_rsp   (out_rsp)
  );

endmodule
